FILE: sv/shd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and beat types for the smoothstep halftone dot pipeline.
// Used by every module of the block; depends on nothing.
package shd_pkg;

   localparam int FRAC_BITS = 16;             // fraction bits of every fixed-point value
   localparam int FRAC_W    = FRAC_BITS + 1;  // holds 0 .. one
   localparam int CDIST_W   = FRAC_BITS + 2;  // holds 0 .. two
   localparam int TSUM_W    = FRAC_BITS + 4;  // 2*c + half before clamping
   localparam int COLOR_W   = 8;
   localparam int OFFSET_W  = 8;
   localparam int CELL_W    = 8;
   localparam int GRAY_W    = 8;
   localparam int DIST_W    = OFFSET_W + 1;   // |2*off - size|
   localparam int REM_W     = 10;             // remainder below the largest divisor

   localparam logic [CELL_W-1:0]  CELL_RESET = 8'd8;
   localparam logic [REM_W-1:0]   LUMA_FULL  = 10'd765;
   localparam logic [FRAC_W-1:0]  FX_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_W-1:0]  FX_HALF    = {2'b01, {(FRAC_BITS - 1){1'b0}}};
   localparam logic [CDIST_W-1:0] FX_TWO     = {2'b10, {FRAC_BITS{1'b0}}};

   // one long-division lane: partial remainder and quotient bits so far
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [FRAC_W-1:0] quo;
   } div_lane_type;

   // beat carried through the division stages
   typedef struct packed {
      div_lane_type      lane_x;
      div_lane_type      lane_y;
      div_lane_type      lane_r;
      logic              sat_x;   // axis distance of two or more
      logic              sat_y;
      logic [CELL_W-1:0] size;    // effective cell size, never zero
   } div_beat_type;

endpackage

FILE: sv/shd_front.sv
`timescale 1ns / 1ps
// Entry stage: dot radius numerator, axis distances and the first quotient bit.
// Depends on shd_pkg.
module shd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [shd_pkg::COLOR_W-1:0]   red,
   input  logic [shd_pkg::COLOR_W-1:0]   green,
   input  logic [shd_pkg::COLOR_W-1:0]   blue,
   input  logic [shd_pkg::OFFSET_W-1:0]  offset_x,
   input  logic [shd_pkg::OFFSET_W-1:0]  offset_y,
   input  logic [shd_pkg::CELL_W-1:0]    cell_size,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output shd_pkg::div_beat_type         dn_beat
);

   logic                   valid_ff, valid_in;
   shd_pkg::div_beat_type  beat_ff, beat_in;
   logic [shd_pkg::CELL_W-1:0] size_eff;
   logic [shd_pkg::REM_W-1:0]  lum_sum;
   logic [shd_pkg::REM_W-1:0]  dark;

   // first quotient bit (weight one) of |2*off - size| / size
   function automatic logic [shd_pkg::REM_W+1:0] axis_start(
      input logic [shd_pkg::OFFSET_W-1:0] off,
      input logic [shd_pkg::CELL_W-1:0]   size
   );
      logic [shd_pkg::DIST_W-1:0] twice;
      logic [shd_pkg::DIST_W-1:0] sz;
      logic [shd_pkg::DIST_W-1:0] span;
      logic                       top;
      logic                       sat;
      logic [shd_pkg::DIST_W-1:0] rem;
      twice = {off, 1'b0};
      sz    = {1'b0, size};
      span  = (twice >= sz) ? (twice - sz) : (sz - twice);
      sat   = span >= {size, 1'b0};
      top   = span >= sz;
      rem   = top ? (span - sz) : span;
      return {sat, top, {(shd_pkg::REM_W - shd_pkg::DIST_W){1'b0}}, rem};
   endfunction

   logic [shd_pkg::REM_W+1:0] start_x, start_y;

   assign size_eff = (cell_size == '0) ? shd_pkg::CELL_W'(1) : cell_size;
   assign lum_sum  = shd_pkg::REM_W'(red) + shd_pkg::REM_W'(green) + shd_pkg::REM_W'(blue);
   assign dark     = shd_pkg::LUMA_FULL - lum_sum;
   assign start_x  = axis_start(offset_x, size_eff);
   assign start_y  = axis_start(offset_y, size_eff);

   always_comb begin
      beat_in            = beat_ff;
      beat_in.size       = size_eff;
      beat_in.sat_x      = start_x[shd_pkg::REM_W+1];
      beat_in.sat_y      = start_y[shd_pkg::REM_W+1];
      beat_in.lane_x.rem = start_x[shd_pkg::REM_W-1:0];
      beat_in.lane_x.quo = shd_pkg::FRAC_W'(start_x[shd_pkg::REM_W]);
      beat_in.lane_y.rem = start_y[shd_pkg::REM_W-1:0];
      beat_in.lane_y.quo = shd_pkg::FRAC_W'(start_y[shd_pkg::REM_W]);
      // only a black pixel reaches a full radius of one
      if (dark == shd_pkg::LUMA_FULL) begin
         beat_in.lane_r.rem = '0;
         beat_in.lane_r.quo = shd_pkg::FRAC_W'(1);
      end else begin
         beat_in.lane_r.rem = dark;
         beat_in.lane_r.quo = '0;
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

FILE: sv/shd_div_stage.sv
`timescale 1ns / 1ps
// One restoring-division stage: one more quotient bit on each of three lanes.
// Depends on shd_pkg.
module shd_div_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  shd_pkg::div_beat_type  up_beat,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output shd_pkg::div_beat_type  dn_beat
);

   logic                   valid_ff, valid_in;
   shd_pkg::div_beat_type  beat_ff, beat_in;

   function automatic shd_pkg::div_lane_type div_step(
      input shd_pkg::div_lane_type     lane,
      input logic [shd_pkg::REM_W-1:0] divisor
   );
      logic [shd_pkg::REM_W:0] rem2;
      logic [shd_pkg::REM_W:0] diff;
      logic                    fits;
      shd_pkg::div_lane_type   res;
      rem2 = {lane.rem, 1'b0};
      diff = rem2 - {1'b0, divisor};
      fits = rem2 >= {1'b0, divisor};
      res.rem = fits ? diff[shd_pkg::REM_W-1:0] : rem2[shd_pkg::REM_W-1:0];
      res.quo = {lane.quo[shd_pkg::FRAC_W-2:0], fits};
      return res;
   endfunction

   always_comb begin
      beat_in        = up_beat;
      beat_in.lane_x = div_step(up_beat.lane_x, shd_pkg::REM_W'(up_beat.size));
      beat_in.lane_y = div_step(up_beat.lane_y, shd_pkg::REM_W'(up_beat.size));
      beat_in.lane_r = div_step(up_beat.lane_r, shd_pkg::LUMA_FULL);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

FILE: sv/shd_shape.sv
`timescale 1ns / 1ps
// Smoothstep shaping and grey output: clamp, square, cubic weight, max and scale.
// Four register stages; depends on shd_pkg.
module shd_shape (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  shd_pkg::div_beat_type         up_beat,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic [shd_pkg::GRAY_W-1:0]    dn_gray
);

   localparam int SQ_W  = 2 * shd_pkg::FRAC_W;
   localparam int CUB_W = 2 * shd_pkg::FRAC_W + 1;
   localparam int OUT_W = shd_pkg::FRAC_W + shd_pkg::GRAY_W;
   localparam logic [shd_pkg::FRAC_W:0] FX_THREE = {2'b11, {shd_pkg::FRAC_BITS{1'b0}}};

   // t = clamp(2c - 2r + half, 0, one)
   function automatic logic [shd_pkg::FRAC_W-1:0] clamp_t(
      input logic [shd_pkg::CDIST_W-1:0] c,
      input logic [shd_pkg::FRAC_W-1:0]  r
   );
      logic [shd_pkg::TSUM_W-1:0] pos;
      logic [shd_pkg::TSUM_W-1:0] neg;
      logic [shd_pkg::TSUM_W-1:0] diff;
      pos  = shd_pkg::TSUM_W'({c, 1'b0}) + shd_pkg::TSUM_W'(shd_pkg::FX_HALF);
      neg  = shd_pkg::TSUM_W'({r, 1'b0});
      diff = pos - neg;
      if (pos <= neg) begin
         return '0;
      end else if (diff >= shd_pkg::TSUM_W'(shd_pkg::FX_ONE)) begin
         return shd_pkg::FX_ONE;
      end else begin
         return diff[shd_pkg::FRAC_W-1:0];
      end
   endfunction

   // stage 1: clamp
   logic                          v1_ff, v1_in, rdy1;
   logic [shd_pkg::FRAC_W-1:0]    tx1_ff, ty1_ff;
   logic [shd_pkg::CDIST_W-1:0]   cx, cy;
   // stage 2: square
   logic                          v2_ff, v2_in, rdy2;
   logic [shd_pkg::FRAC_W-1:0]    tx2_ff, ty2_ff, sqx2_ff, sqy2_ff;
   logic [SQ_W-1:0]               sqx, sqy;
   // stage 3: cubic weight
   logic                          v3_ff, v3_in, rdy3;
   logic [shd_pkg::FRAC_W-1:0]    sx3_ff, sy3_ff;
   logic [shd_pkg::FRAC_W:0]      wx, wy;
   logic [CUB_W-1:0]              cubx, cuby;
   // stage 4: max and scale to 0..255
   logic                          v4_ff, v4_in, rdy4;
   logic [shd_pkg::GRAY_W-1:0]    gray4_ff;
   logic [shd_pkg::FRAC_W-1:0]    smax;
   logic [OUT_W-1:0]              scaled;

   assign cx = up_beat.sat_x ? shd_pkg::FX_TWO : shd_pkg::CDIST_W'(up_beat.lane_x.quo);
   assign cy = up_beat.sat_y ? shd_pkg::FX_TWO : shd_pkg::CDIST_W'(up_beat.lane_y.quo);

   assign sqx = SQ_W'(tx1_ff) * SQ_W'(tx1_ff);
   assign sqy = SQ_W'(ty1_ff) * SQ_W'(ty1_ff);

   assign wx   = FX_THREE - {tx2_ff, 1'b0};
   assign wy   = FX_THREE - {ty2_ff, 1'b0};
   assign cubx = CUB_W'(sqx2_ff) * CUB_W'(wx);
   assign cuby = CUB_W'(sqy2_ff) * CUB_W'(wy);

   assign smax   = (sx3_ff > sy3_ff) ? sx3_ff : sy3_ff;
   // times 255 as times 256 minus one
   assign scaled = {smax, {shd_pkg::GRAY_W{1'b0}}} - OUT_W'(smax);

   assign rdy4     = !v4_ff || dn_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign up_ready = rdy1;

   assign v1_in = rdy1 ? up_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && up_valid) begin
         tx1_ff <= clamp_t(cx, up_beat.lane_r.quo);
         ty1_ff <= clamp_t(cy, up_beat.lane_r.quo);
      end
      if (rdy2 && v1_ff) begin
         tx2_ff  <= tx1_ff;
         ty2_ff  <= ty1_ff;
         sqx2_ff <= sqx[2*shd_pkg::FRAC_BITS:shd_pkg::FRAC_BITS];
         sqy2_ff <= sqy[2*shd_pkg::FRAC_BITS:shd_pkg::FRAC_BITS];
      end
      if (rdy3 && v2_ff) begin
         sx3_ff <= cubx[2*shd_pkg::FRAC_BITS:shd_pkg::FRAC_BITS];
         sy3_ff <= cuby[2*shd_pkg::FRAC_BITS:shd_pkg::FRAC_BITS];
      end
      if (rdy4 && v3_ff) begin
         gray4_ff <= scaled[shd_pkg::FRAC_BITS+shd_pkg::GRAY_W-1:shd_pkg::FRAC_BITS];
      end
   end

   assign dn_valid = v4_ff;
   assign dn_gray  = gray4_ff;

endmodule

FILE: sv/smoothstep_halftone_dot.sv
`timescale 1ns / 1ps
// Top level of the smoothstep halftone dot pipeline.
// Depends on shd_pkg, shd_front, shd_div_stage and shd_shape.
//
// Turns one source color plus a pixel position inside a square halftone
// cell into the grey level of that output pixel; darker colors give larger
// dots with soft smoothstep edges.
// req_* carries one pixel beat (red, green, blue, offset_x, offset_y) with
// valid/ready; rsp_* returns one gray beat per request, in order.
// csr_wr_en/csr_wr_data write the cell size (0 acts as 1); write it only
// while no beat is in flight.
// The pipeline has one entry stage, one divider stage per fraction bit of
// the three-lane long division, and four shaping stages.
// Throughput is one beat per cycle unless the receiver stalls; every stage
// has its own valid bit and takes a new beat whenever it is empty or its
// successor moves.
// When the receiver stalls, the response holds and beats pile up behind it;
// req_ready drops only once every stage is occupied.
// Reset empties the pipeline and sets the cell size to 8.
module smoothstep_halftone_dot (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [shd_pkg::COLOR_W-1:0]   req_red,
   input  logic [shd_pkg::COLOR_W-1:0]   req_green,
   input  logic [shd_pkg::COLOR_W-1:0]   req_blue,
   input  logic [shd_pkg::OFFSET_W-1:0]  req_offset_x,
   input  logic [shd_pkg::OFFSET_W-1:0]  req_offset_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [shd_pkg::GRAY_W-1:0]    rsp_gray,
   input  logic                          csr_wr_en,
   input  logic [shd_pkg::CELL_W-1:0]    csr_wr_data
);

   logic [shd_pkg::CELL_W-1:0] cell_size_ff, cell_size_in;

   logic                  stage_valid [0:shd_pkg::FRAC_BITS];
   logic                  stage_ready [0:shd_pkg::FRAC_BITS];
   shd_pkg::div_beat_type stage_beat  [0:shd_pkg::FRAC_BITS];

   assign cell_size_in = csr_wr_en ? csr_wr_data : cell_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= shd_pkg::CELL_RESET;
      end else begin
         cell_size_ff <= cell_size_in;
      end
   end

   shd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (req_valid),
      .up_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .offset_x  (req_offset_x),
      .offset_y  (req_offset_y),
      .cell_size (cell_size_ff),
      .dn_valid  (stage_valid[0]),
      .dn_ready  (stage_ready[0]),
      .dn_beat   (stage_beat[0])
   );

   // one quotient bit per stage below the weight-one bit
   for (genvar i = 0; i < shd_pkg::FRAC_BITS; i++) begin : g_div
      shd_div_stage u_div (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[i]),
         .up_ready (stage_ready[i]),
         .up_beat  (stage_beat[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_ready (stage_ready[i+1]),
         .dn_beat  (stage_beat[i+1])
      );
   end

   shd_shape u_shape (
      .clock    (clock),
      .reset    (reset),
      .up_valid (stage_valid[shd_pkg::FRAC_BITS]),
      .up_ready (stage_ready[shd_pkg::FRAC_BITS]),
      .up_beat  (stage_beat[shd_pkg::FRAC_BITS]),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .dn_gray  (rsp_gray)
   );

endmodule

FILE: sv/shd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for smoothstep_halftone_dot, attached by bind.
// Depends on shd_pkg for field widths.
module shd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [shd_pkg::GRAY_W-1:0]    rsp_gray
);

   // a stalled response beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_gray))
      else $error("response gray changed while stalled");

   // an empty or draining output stage lets every stage behind it move
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled with output free");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind smoothstep_halftone_dot shd_checker u_shd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_gray  (rsp_gray)
);

FILE: sim/tb_smoothstep_halftone_dot.sv
`timescale 1ns / 1ps
// Self-checking bench for smoothstep_halftone_dot: directed pixel table, then random cells.
// Depends on shd_pkg and the smoothstep_halftone_dot RTL.
module tb_smoothstep_halftone_dot;
   import shd_pkg::*;

   localparam int PIPE_LATENCY  = FRAC_BITS + 5;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS  = 104;
   localparam int ROW_COUNT     = 21;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_len;
      logic [COLOR_W-1:0]  red;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  blue;
      logic [OFFSET_W-1:0] ox;
      logic [OFFSET_W-1:0] oy;
      logic                has_gray;
      logic [GRAY_W-1:0]   gray;
   } dot_row_type;

   // cell size, red, green, blue, offset_x, offset_y, typed?, gray
   localparam dot_row_type DOT_ROWS [ROW_COUNT] = '{
      '{8,   0,   0,   0,   4,   4,   1, 0},    // black at center, reset cell size
      '{8,   255, 255, 255, 254, 254, 1, 255},  // offsets outside the cell
      '{8,   0,   0,   0,   0,   4,   1, 127},  // black at cell edge
      '{8,   255, 255, 255, 4,   4,   1, 127},  // white at center
      '{8,   128, 64,  32,  3,   6,   0, 0},
      '{8,   255, 0,   0,   7,   0,   0, 0},
      '{8,   0,   255, 0,   1,   5,   0, 0},
      '{8,   0,   0,   255, 6,   2,   0, 0},
      '{8,   170, 85,  170, 8,   8,   0, 0},    // offset equal to cell size
      '{0,   255, 255, 255, 0,   0,   1, 255},  // zero cell size acts as one
      '{0,   0,   0,   0,   0,   0,   0, 0},
      '{1,   0,   0,   0,   0,   0,   0, 0},
      '{1,   100, 100, 100, 200, 3,   0, 0},
      '{255, 0,   0,   0,   127, 127, 1, 0},
      '{255, 0,   0,   0,   0,   0,   1, 127},
      '{255, 255, 255, 255, 254, 254, 0, 0},
      '{255, 85,  170, 85,  64,  191, 0, 0},
      '{2,   127, 128, 255, 1,   0,   0, 0},
      '{2,   1,   2,   4,   1,   1,   0, 0},
      '{7,   254, 253, 251, 3,   6,   0, 0},
      '{8,   60,  60,  60,  2,   2,   0, 0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [COLOR_W-1:0]  req_red = '0;
   logic [COLOR_W-1:0]  req_green = '0;
   logic [COLOR_W-1:0]  req_blue = '0;
   logic [OFFSET_W-1:0] req_offset_x = '0;
   logic [OFFSET_W-1:0] req_offset_y = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [GRAY_W-1:0]   rsp_gray;
   logic                csr_wr_en = 1'b0;
   logic [CELL_W-1:0]   csr_wr_data = '0;

   logic [CELL_W-1:0]   cell_model = CELL_RESET;
   logic [GRAY_W-1:0]   gray_due [$];
   logic                typed_gray_on = 1'b0;
   logic [GRAY_W-1:0]   typed_gray = '0;
   bit                  send_gaps_on = 1'b1;
   bit                  recv_stalls_on = 1'b1;
   int                  fail_count = 0;
   int                  gray_beats = 0;
   int                  cycle_count = 0;

   smoothstep_halftone_dot u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .req_offset_x (req_offset_x),
      .req_offset_y (req_offset_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gray     (rsp_gray),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // distance of one axis from the cell center, as a fraction of half the cell
   function automatic longint axis_dist(input longint off, input longint size);
      longint d;
      d = 2 * off - size;
      if (d < 0) d = -d;
      return (d << FRAC_BITS) / size;
   endfunction

   function automatic longint dot_shape(input longint c, input longint r);
      longint one;
      longint t;
      longint t2;
      one = longint'(1) << FRAC_BITS;
      t = 2 * c - 2 * r + (longint'(1) << (FRAC_BITS - 1));
      if (t < 0) t = 0;
      if (t > one) t = one;
      t2 = (t * t) >> FRAC_BITS;
      return (t2 * (3 * one - 2 * t)) >> FRAC_BITS;
   endfunction

   function automatic logic [GRAY_W-1:0] halftone_gray(
      input logic [COLOR_W-1:0]  red, green, blue,
      input logic [OFFSET_W-1:0] ox, oy,
      input logic [CELL_W-1:0]   cell_len
   );
      longint size;
      longint sum;
      longint radius;
      longint sx;
      longint sy;
      longint peak;
      longint level;
      size = (cell_len == 0) ? 1 : longint'(cell_len);
      sum = longint'(red) + longint'(green) + longint'(blue);
      radius = ((765 - sum) << FRAC_BITS) / 765;
      sx = dot_shape(axis_dist(longint'(ox), size), radius);
      sy = dot_shape(axis_dist(longint'(oy), size), radius);
      peak = (sx > sy) ? sx : sy;
      level = (peak * 255) >> FRAC_BITS;
      return level[GRAY_W-1:0];
   endfunction

   // mostly short, a few long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return '0;
      if (pick < 30) return '1;
      return COLOR_W'($urandom_range(0, 255));
   endfunction

   task automatic send_pixel(
      input logic [COLOR_W-1:0]  red, green, blue,
      input logic [OFFSET_W-1:0] ox, oy,
      input logic                has_gray,
      input logic [GRAY_W-1:0]   gray
   );
      int gap;
      gap = (send_gaps_on && $urandom_range(0, 99) >= 60) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_red       = red;
      req_green     = green;
      req_blue      = blue;
      req_offset_x  = ox;
      req_offset_y  = oy;
      typed_gray_on = has_gray;
      typed_gray    = gray;
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and hold until every pending gray beat is back
   task automatic drain_pixels();
      @(negedge clock);
      req_valid = 1'b0;
      while (gray_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_cell(input logic [CELL_W-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      cell_model  = value;
   endtask

   always @(posedge clock) begin
      logic [GRAY_W-1:0] due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            gray_due.push_back(typed_gray_on ? typed_gray :
               halftone_gray(req_red, req_green, req_blue, req_offset_x, req_offset_y,
                             cell_model));
         end
         if (rsp_valid && rsp_ready) begin
            if (gray_due.size() == 0) begin
               if (fail_count < 10)
                  $display("gray beat %0d arrived with no pixel pending: got %0d",
                           gray_beats, rsp_gray);
               fail_count++;
            end else begin
               due = gray_due.pop_front();
               if (rsp_gray !== due) begin
                  if (fail_count < 10)
                     $display("gray beat %0d mismatch: expected %0d, got %0d",
                              gray_beats, due, rsp_gray);
                  fail_count++;
               end
            end
            gray_beats++;
         end
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (recv_stalls_on && $urandom_range(0, 99) < 25) begin
            rsp_ready = 1'b0;
            stall_left = idle_length() - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int eff;
      logic [CELL_W-1:0]   next_cell;
      logic [COLOR_W-1:0]  red, green, blue;
      logic [OFFSET_W-1:0] ox, oy;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int row = 0; row < ROW_COUNT; row++) begin
         if (DOT_ROWS[row].cell_len != cell_model) begin
            drain_pixels();
            write_cell(DOT_ROWS[row].cell_len);
         end
         send_pixel(DOT_ROWS[row].red, DOT_ROWS[row].green, DOT_ROWS[row].blue,
                    DOT_ROWS[row].ox, DOT_ROWS[row].oy,
                    DOT_ROWS[row].has_gray, DOT_ROWS[row].gray);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       next_cell = 8'd1;
            1:       next_cell = 8'd255;
            2:       next_cell = 8'd0;
            3:       next_cell = 8'd2;
            default: next_cell = ($urandom_range(0, 2) == 0) ? CELL_W'($urandom_range(1, 255))
                                                             : CELL_W'($urandom_range(3, 16));
         endcase
         drain_pixels();
         write_cell(next_cell);
         send_gaps_on   = (phase % 4 != 1);
         recv_stalls_on = (phase % 4 != 1);
         eff = (cell_model == 0) ? 1 : int'(cell_model);
         for (int item = 0; item < PHASE_PIXELS; item++) begin
            if (phase == 6 && item == 50) drain_pixels();
            red   = pick_color();
            green = pick_color();
            blue  = pick_color();
            if ($urandom_range(0, 9) == 0) begin
               green = red;
               blue  = red;
            end
            // most offsets inside the cell, a few past its edge
            ox = OFFSET_W'($urandom_range(0, eff - 1));
            oy = OFFSET_W'($urandom_range(0, eff - 1));
            if (eff <= 254 && $urandom_range(0, 9) == 0) ox = OFFSET_W'($urandom_range(eff, 254));
            if (eff <= 254 && $urandom_range(0, 9) == 0) oy = OFFSET_W'($urandom_range(eff, 254));
            send_pixel(red, green, blue, ox, oy, 1'b0, '0);
         end
      end

      drain_pixels();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (gray_due.size() != 0) begin
         $display("%0d gray beats never arrived", gray_due.size());
         fail_count += gray_due.size();
      end
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
